// ===== hdl/mvd_pkg.sv =====
// ----------------------------------------------------------------------------
// mvd_pkg
// Shared constants and types of the majority vote debounce block.
// ----------------------------------------------------------------------------
package mvd_pkg;

  localparam int SAMPLES_PER_ROUND = 10;
  localparam int HISTORY_DEPTH     = 20;

  localparam int CHANNELS  = 4;
  localparam int DIRECT_W  = 8;
  localparam int AUDIO_W   = 12;
  localparam int SUM_W     = 16;
  localparam int COUNT_W   = 4;
  localparam int TOGGLE_W  = 6;
  localparam int TOG_OUT_W = 5;

  localparam logic [COUNT_W-1:0] THRESHOLD_RESET = 4'd7;

  // register map
  localparam int  ADDR_W             = 3;
  localparam int  DATA_W             = 32;
  localparam logic REG_VOTE_THRESHOLD = 1'b0;

  typedef struct packed {
    logic take;
    logic last;
  } lane_ctl_t;

  typedef struct packed {
    logic here;
    logic prev_bit;
    logic next_bit;
  } ring_taps_t;

endpackage

// ===== hdl/mvd_if.sv =====
// ----------------------------------------------------------------------------
// mvd_sample_if / mvd_result_if
// Valid/ready channels for raw samples and per-round results.
// ----------------------------------------------------------------------------
interface mvd_sample_if;
  logic                           valid;
  logic                           ready;
  logic [mvd_pkg::CHANNELS-1:0]   voted_raw_bits;
  logic [mvd_pkg::DIRECT_W-1:0]   direct_raw_bits;
  logic [mvd_pkg::AUDIO_W-1:0]    audio_sample;

  modport source (output valid, voted_raw_bits, direct_raw_bits, audio_sample, input ready);
  modport sink   (input valid, voted_raw_bits, direct_raw_bits, audio_sample, output ready);
endinterface

interface mvd_result_if;
  logic                           valid;
  logic                           ready;
  logic [mvd_pkg::CHANNELS-1:0]   voted_touch;
  logic [mvd_pkg::DIRECT_W-1:0]   direct_touch;
  logic [mvd_pkg::TOG_OUT_W-1:0]  toggles_ch0;
  logic [mvd_pkg::TOG_OUT_W-1:0]  toggles_ch1;
  logic [mvd_pkg::TOG_OUT_W-1:0]  toggles_ch2;
  logic [mvd_pkg::TOG_OUT_W-1:0]  toggles_ch3;
  logic [mvd_pkg::AUDIO_W-1:0]    audio_average;

  modport source (output valid, voted_touch, direct_touch, toggles_ch0, toggles_ch1,
                  toggles_ch2, toggles_ch3, audio_average, input ready);
  modport sink   (input valid, voted_touch, direct_touch, toggles_ch0, toggles_ch1,
                  toggles_ch2, toggles_ch3, audio_average, output ready);
endinterface

// ===== hdl/mvd_lane.sv =====
// ----------------------------------------------------------------------------
// mvd_lane
// One voted channel: high-sample counter, threshold vote, toggle count.
// ----------------------------------------------------------------------------
module mvd_lane (
  input  logic                          clk,
  input  logic                          rst,
  input  mvd_pkg::lane_ctl_t            ctl,
  input  logic                          raw_bit,
  input  logic [mvd_pkg::COUNT_W-1:0]   threshold,
  input  mvd_pkg::ring_taps_t           taps,
  output logic                          voted,
  output logic [mvd_pkg::TOGGLE_W-1:0]  toggles_next
);

  logic [mvd_pkg::COUNT_W-1:0]  count;
  logic [mvd_pkg::COUNT_W-1:0]  count_next;
  logic [mvd_pkg::TOGGLE_W-1:0] toggles;
  logic [1:0]                   old_mism;
  logic [1:0]                   new_mism;

  assign count_next = count + mvd_pkg::COUNT_W'(raw_bit);
  assign voted      = (count_next >= threshold);

  // mismatches of the current slot with its two ring neighbors, before and after
  assign old_mism = 2'(taps.here != taps.prev_bit) + 2'(taps.here != taps.next_bit);
  assign new_mism = 2'(voted != taps.prev_bit) + 2'(voted != taps.next_bit);

  assign toggles_next = toggles - mvd_pkg::TOGGLE_W'(old_mism)
                                + mvd_pkg::TOGGLE_W'(new_mism);

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      toggles <= '0;
    end else if (ctl.take) begin
      if (ctl.last) begin
        count   <= '0;
        toggles <= toggles_next;
      end else begin
        count <= count_next;
      end
    end
  end

endmodule

// ===== hdl/mvd_average.sv =====
// ----------------------------------------------------------------------------
// mvd_average
// Round audio sum divided by the sample count, by registered reciprocal multiply.
// ----------------------------------------------------------------------------
module mvd_average #(
  parameter int DIVISOR = mvd_pkg::SAMPLES_PER_ROUND
) (
  input  logic                         clk,
  input  logic                         load,
  input  logic [mvd_pkg::SUM_W-1:0]    sum,
  output logic [mvd_pkg::AUDIO_W-1:0]  average
);

  // exact floor for every dividend below 2**SUM_W
  localparam int SHIFT  = mvd_pkg::SUM_W + $clog2(DIVISOR);
  localparam int MULT_W = mvd_pkg::SUM_W + 2;
  localparam longint unsigned MULT = ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam int PROD_W = mvd_pkg::SUM_W + MULT_W;

  localparam logic [MULT_W-1:0] MULT_K = MULT_W'(MULT);

  logic [PROD_W-1:0] product;

  always_ff @(posedge clk) begin
    if (load) begin
      product <= PROD_W'(sum) * PROD_W'(MULT_K);
    end
  end

  assign average = product[SHIFT +: mvd_pkg::AUDIO_W];

endmodule

// ===== hdl/majority_vote_debounce_with_toggle_count.sv =====
// ----------------------------------------------------------------------------
// majority_vote_debounce_with_toggle_count
// Round-based touch debounce with history toggle counts and audio averaging.
// ----------------------------------------------------------------------------
// One raw sample is taken per clock cycle while input ready is high. Every
// SAMPLES_PER_ROUND samples make a round; the round's last sample produces one
// result via the s1 and output registers. Four channel lanes vote and update
// their toggle counts in the cycle that takes the last sample, and the history
// ring is a shift line that rotates once per round so the slot being written
// is always at one tap. The audio average goes through one registered reciprocal
// multiplier stage. Input ready drops only while a finished round and the output
// register both wait on a stalled sink. History and counts clear at reset.
module majority_vote_debounce_with_toggle_count #(
  parameter int SAMPLES_PER_ROUND = mvd_pkg::SAMPLES_PER_ROUND,
  parameter int HISTORY_DEPTH     = mvd_pkg::HISTORY_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mvd_pkg::ADDR_W-1:0]   paddr,
  input  logic [mvd_pkg::DATA_W-1:0]   pwdata,
  output logic [mvd_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  mvd_sample_if.sink                   samples,
  mvd_result_if.source                 results
);

  localparam int CH = mvd_pkg::CHANNELS;

  // ---------------- configuration ----------------
  logic [mvd_pkg::COUNT_W-1:0] vote_threshold;
  logic                        reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == mvd_pkg::REG_VOTE_THRESHOLD);
  assign prdata  = reg_sel ? mvd_pkg::DATA_W'(vote_threshold) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vote_threshold <= mvd_pkg::THRESHOLD_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      vote_threshold <= pwdata[mvd_pkg::COUNT_W-1:0];
    end
  end

  // ---------------- round bookkeeping ----------------
  logic                        take;
  logic                        last;
  logic [mvd_pkg::COUNT_W-1:0] sample_counter;
  logic [mvd_pkg::SUM_W-1:0]   audio_sum;
  logic [mvd_pkg::SUM_W-1:0]   audio_sum_next;
  mvd_pkg::lane_ctl_t          ctl;

  assign take           = samples.valid && samples.ready;
  assign last           = (sample_counter == mvd_pkg::COUNT_W'(SAMPLES_PER_ROUND - 1));
  assign audio_sum_next = audio_sum + mvd_pkg::SUM_W'(samples.audio_sample);
  assign ctl.take       = take;
  assign ctl.last       = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_counter <= '0;
      audio_sum      <= '0;
    end else if (take) begin
      if (last) begin
        sample_counter <= '0;
        audio_sum      <= '0;
      end else begin
        sample_counter <= sample_counter + mvd_pkg::COUNT_W'(1);
        audio_sum      <= audio_sum_next;
      end
    end
  end

  // ---------------- history ring ----------------
  // ring[0] is the slot this round writes, ring[1] the next, ring[DEPTH-1] the previous
  logic [CH-1:0] ring [HISTORY_DEPTH];
  logic [CH-1:0] voted;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        ring[i] <= '0;
      end
    end else if (take && last) begin
      for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
        ring[i] <= ring[i + 1];
      end
      ring[HISTORY_DEPTH - 1] <= voted;
    end
  end

  // ---------------- channel lanes ----------------
  logic [mvd_pkg::TOGGLE_W-1:0] toggles_next [CH];

  for (genvar c = 0; c < CH; c++) begin : g_lane
    mvd_pkg::ring_taps_t taps;

    assign taps.here     = ring[0][c];
    assign taps.prev_bit = ring[HISTORY_DEPTH - 1][c];
    assign taps.next_bit = ring[1][c];

    mvd_lane u_lane (
      .clk          (clk),
      .rst          (rst),
      .ctl          (ctl),
      .raw_bit      (samples.voted_raw_bits[c]),
      .threshold    (vote_threshold),
      .taps         (taps),
      .voted        (voted[c]),
      .toggles_next (toggles_next[c])
    );
  end

  // ---------------- merge and output pipeline ----------------
  logic                          s1_valid;
  logic [CH-1:0]                 s1_voted;
  logic [mvd_pkg::DIRECT_W-1:0]  s1_direct;
  logic [mvd_pkg::TOG_OUT_W-1:0] s1_toggles [CH];
  logic [mvd_pkg::SUM_W-1:0]     s1_sum;
  logic                          advance;
  logic                          out_valid;

  assign advance       = s1_valid && (!out_valid || results.ready);
  assign samples.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take && last) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && last) begin
      s1_voted  <= voted;
      s1_direct <= samples.direct_raw_bits;
      s1_sum    <= audio_sum_next;
      for (int c = 0; c < CH; c++) begin
        s1_toggles[c] <= toggles_next[c][mvd_pkg::TOG_OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      results.voted_touch  <= s1_voted;
      results.direct_touch <= s1_direct;
      results.toggles_ch0  <= s1_toggles[0];
      results.toggles_ch1  <= s1_toggles[1];
      results.toggles_ch2  <= s1_toggles[2];
      results.toggles_ch3  <= s1_toggles[3];
    end
  end

  mvd_average #(
    .DIVISOR (SAMPLES_PER_ROUND)
  ) u_average (
    .clk     (clk),
    .load    (advance),
    .sum     (s1_sum),
    .average (results.audio_average)
  );

  assign results.valid = out_valid;

endmodule

// ===== bench/mvd_round_checker.sv =====
// ----------------------------------------------------------------------------
// mvd_round_checker
// Watches the sample, result and register ports of the debounce block, keeps
// its own model of the round state, history ring and toggle counts, and
// compares every result transaction with the oldest predicted round.
// ----------------------------------------------------------------------------
package mvd_tb_pkg;
  localparam logic [mvd_pkg::ADDR_W-1:0] THRESHOLD_ADDR = {mvd_pkg::REG_VOTE_THRESHOLD, 2'b00};
endpackage

module mvd_round_checker
  import mvd_pkg::*;
  import mvd_tb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  input  logic [DATA_W-1:0] prdata,
  mvd_sample_if             samples,
  mvd_result_if             results,
  output int                fail_count,
  output int                pending
);

  typedef struct packed {
    logic [CHANNELS-1:0]                 voted;
    logic [DIRECT_W-1:0]                 direct;
    logic [CHANNELS-1:0][TOG_OUT_W-1:0]  toggles;
    logic [AUDIO_W-1:0]                  average;
  } round_result_t;

  logic [COUNT_W-1:0]  threshold;
  logic [3:0]          round_fill;
  logic [COUNT_W-1:0]  highs [CHANNELS];
  logic [SUM_W-1:0]    audio_total;
  logic [CHANNELS-1:0] ring [HISTORY_DEPTH];
  int unsigned         slot;
  logic [TOGGLE_W-1:0] toggles [CHANNELS];
  round_result_t       rounds_due [$];

  // mismatches of one ring slot with both neighbors, for one channel
  function automatic int unsigned slot_disagreements(input int unsigned s, input int ch);
    int unsigned prev_s;
    int unsigned next_s;
    prev_s = (s == 0) ? HISTORY_DEPTH - 1 : s - 1;
    next_s = (s + 1 >= HISTORY_DEPTH) ? 0 : s + 1;
    return int'(ring[s][ch] != ring[prev_s][ch]) + int'(ring[s][ch] != ring[next_s][ch]);
  endfunction

  task automatic absorb_sample(input logic [CHANNELS-1:0] raw,
                               input logic [DIRECT_W-1:0] direct,
                               input logic [AUDIO_W-1:0]  audio);
    round_result_t       r;
    logic [CHANNELS-1:0] voted;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      highs[ch] = highs[ch] + COUNT_W'(raw[ch]);
    end
    audio_total = audio_total + SUM_W'(audio);
    round_fill  = round_fill + 4'd1;
    if (round_fill >= SAMPLES_PER_ROUND) begin
      voted = '0;
      for (int ch = 0; ch < CHANNELS; ch++) begin
        if (highs[ch] >= threshold) begin
          voted[ch] = 1'b1;
        end
        toggles[ch] = TOGGLE_W'(toggles[ch] - slot_disagreements(slot, ch));
      end
      ring[slot] = voted;
      for (int ch = 0; ch < CHANNELS; ch++) begin
        toggles[ch]    = TOGGLE_W'(toggles[ch] + slot_disagreements(slot, ch));
        r.toggles[ch]  = toggles[ch][TOG_OUT_W-1:0];
      end
      r.voted   = voted;
      r.direct  = direct;
      r.average = AUDIO_W'(audio_total / SAMPLES_PER_ROUND);
      rounds_due.push_back(r);
      slot        = (slot + 1 >= HISTORY_DEPTH) ? 0 : slot + 1;
      round_fill  = '0;
      audio_total = '0;
      for (int ch = 0; ch < CHANNELS; ch++) begin
        highs[ch] = '0;
      end
    end
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    round_result_t                      want;
    logic [CHANNELS-1:0][TOG_OUT_W-1:0] seen_toggles;
    if (rst) begin
      threshold   = THRESHOLD_RESET;
      round_fill  = '0;
      audio_total = '0;
      slot        = 0;
      for (int ch = 0; ch < CHANNELS; ch++) begin
        highs[ch]   = '0;
        toggles[ch] = '0;
      end
      for (int s = 0; s < HISTORY_DEPTH; s++) begin
        ring[s] = '0;
      end
      rounds_due.delete();
      fail_count = 0;
    end else begin
      if (psel && penable && pready && paddr == THRESHOLD_ADDR) begin
        if (pwrite) begin
          threshold = pwdata[COUNT_W-1:0];
        end else begin
          check_field("vote_threshold readback", threshold, prdata);
        end
      end
      if (results.valid && results.ready) begin
        if (rounds_due.size() == 0) begin
          fail_count++;
          $display("%0t: result transaction with no round pending, expected none, actual %h",
                   $time, results.voted_touch);
        end else begin
          want = rounds_due.pop_front();
          seen_toggles = {results.toggles_ch3, results.toggles_ch2,
                          results.toggles_ch1, results.toggles_ch0};
          check_field("voted_touch", want.voted, results.voted_touch);
          check_field("direct_touch", want.direct, results.direct_touch);
          for (int ch = 0; ch < CHANNELS; ch++) begin
            check_field($sformatf("toggles_ch%0d", ch), want.toggles[ch], seen_toggles[ch]);
          end
          check_field("audio_average", want.average, results.audio_average);
        end
      end
      if (samples.valid && samples.ready) begin
        absorb_sample(samples.voted_raw_bits, samples.direct_raw_bits, samples.audio_sample);
      end
    end
    pending = rounds_due.size();
  end

endmodule

// ===== bench/tb_majority_vote_debounce_with_toggle_count.sv =====
// ----------------------------------------------------------------------------
// tb_majority_vote_debounce_with_toggle_count
// Drives raw sample rounds through the debounce block under several vote
// thresholds, with bursty input, a stalling result sink and long hold-offs;
// the round checker beside the block predicts and compares each result.
// ----------------------------------------------------------------------------
module tb_majority_vote_debounce_with_toggle_count;
  import mvd_pkg::*;
  import mvd_tb_pkg::*;

  localparam int CLK_PERIOD       = 12;
  localparam int RESET_CYCLES     = 6;
  localparam int DRAIN_CYCLES     = 8;
  localparam int LIMIT_CYCLES     = 500000;
  localparam int ROUNDS_PER_PHASE = 24;
  localparam int HOLD_PERIOD      = 700;
  localparam int HOLD_LENGTH      = 150;

  // register index 1 has no register behind it
  localparam logic [ADDR_W-1:0] UNMAPPED_ADDR = {1'b1, 2'b00};

  typedef enum int {
    ROUND_NOISE,
    ROUND_ALL_HIGH,
    ROUND_ALL_LOW,
    ROUND_NEAR_THRESHOLD,
    ROUND_ALTERNATE
  } round_kind_t;

  typedef enum int {
    SINK_ALWAYS,
    SINK_PATTERN,
    SINK_RANDOM
  } sink_mode_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  int                fail_count;
  int                pending;

  mvd_sample_if sample_ch ();
  mvd_result_if result_ch ();

  logic [COUNT_W-1:0]  threshold_now;
  logic [CHANNELS-1:0] alt_level;
  int                  burst_left;

  always #(CLK_PERIOD / 2) clk = ~clk;

  majority_vote_debounce_with_toggle_count DUT (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .samples (sample_ch),
    .results (result_ch)
  );

  mvd_round_checker round_checker (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .samples    (sample_ch),
    .results    (result_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  task automatic offer_sample(input logic [CHANNELS-1:0] raw,
                              input logic [DIRECT_W-1:0] direct,
                              input logic [AUDIO_W-1:0]  audio);
    sample_ch.valid           <= 1'b1;
    sample_ch.voted_raw_bits  <= raw;
    sample_ch.direct_raw_bits <= direct;
    sample_ch.audio_sample    <= audio;
    do @(posedge clk); while (!sample_ch.ready);
  endtask

  // bursts of random length, some long ones with no gaps at all
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 30);
      if (gap > 0) begin
        sample_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic send_round(input round_kind_t kind);
    logic [SAMPLES_PER_ROUND-1:0] lane [CHANNELS];
    logic [CHANNELS-1:0]          raw;
    logic [AUDIO_W-1:0]           audio;
    int                           want;
    int                           placed;
    int                           pos;
    int                           audio_style;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      case (kind)
        ROUND_ALL_HIGH: begin
          lane[ch] = '1;
        end
        ROUND_ALL_LOW: begin
          lane[ch] = '0;
        end
        ROUND_ALTERNATE: begin
          lane[ch] = alt_level[ch] ? '1 : '0;
        end
        ROUND_NEAR_THRESHOLD: begin
          // threshold-1, threshold or threshold+1 high samples, clamped to 0..SAMPLES_PER_ROUND
          want = int'(threshold_now) + int'($urandom_range(0, 2)) - 1;
          if (want < 0) want = 0;
          if (want > SAMPLES_PER_ROUND) want = SAMPLES_PER_ROUND;
          lane[ch] = '0;
          placed   = 0;
          while (placed < want) begin
            pos = $urandom_range(0, SAMPLES_PER_ROUND - 1);
            if (!lane[ch][pos]) begin
              lane[ch][pos] = 1'b1;
              placed++;
            end
          end
        end
        default: begin
          lane[ch] = SAMPLES_PER_ROUND'($urandom());
        end
      endcase
    end
    if (kind == ROUND_ALTERNATE) begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
        if ($urandom_range(0, 7) != 0) alt_level[ch] = ~alt_level[ch];
      end
    end
    audio_style = $urandom_range(0, 9);
    for (int i = 0; i < SAMPLES_PER_ROUND; i++) begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
        raw[ch] = lane[ch][i];
      end
      case (audio_style)
        0:       audio = '1;
        1:       audio = '0;
        default: audio = AUDIO_W'($urandom_range(0, 4095));
      endcase
      pace();
      offer_sample(raw, DIRECT_W'($urandom_range(0, 255)), audio);
    end
  endtask

  task automatic send_random_rounds(input int count);
    int pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 30)      send_round(ROUND_ALTERNATE);
      else if (pick < 55) send_round(ROUND_NEAR_THRESHOLD);
      else if (pick < 75) send_round(ROUND_NOISE);
      else if (pick < 87) send_round(ROUND_ALL_HIGH);
      else                send_round(ROUND_ALL_LOW);
    end
  endtask

  // setup, access, then idle with psel low before the next transfer
  task automatic apb_access(input logic write, input logic [ADDR_W-1:0] addr,
                            input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // all rounds out and the pipeline drained
  task automatic settle();
    sample_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [COUNT_W-1:0] threshold_plan [7];
    threshold_plan = '{4'd0, 4'd10, 4'd15, 4'd1, 4'd6, 4'd4, 4'd9};
    rst                       <= 1'b1;
    psel                      <= 1'b0;
    penable                   <= 1'b0;
    pwrite                    <= 1'b0;
    paddr                     <= '0;
    pwdata                    <= '0;
    sample_ch.valid           <= 1'b0;
    sample_ch.voted_raw_bits  <= '0;
    sample_ch.direct_raw_bits <= '0;
    sample_ch.audio_sample    <= '0;
    threshold_now = THRESHOLD_RESET;
    alt_level     = '0;
    burst_left    = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    apb_access(1'b0, THRESHOLD_ADDR, '0);

    // channel 0 always high, channel 1 exactly at the reset threshold,
    // channel 2 one short, channel 3 never; full-scale audio
    for (int i = 0; i < SAMPLES_PER_ROUND; i++) begin
      pace();
      offer_sample({1'b0, i < 6, i < 7, 1'b1},
                   (i == SAMPLES_PER_ROUND - 1) ? 8'hFF : 8'h00, '1);
    end
    // quiet round, zero audio
    for (int i = 0; i < SAMPLES_PER_ROUND; i++) begin
      pace();
      offer_sample('0, (i == SAMPLES_PER_ROUND - 1) ? 8'h00 : 8'hFF, '0);
    end
    send_random_rounds(ROUNDS_PER_PHASE);

    foreach (threshold_plan[p]) begin
      settle();
      apb_access(1'b1, THRESHOLD_ADDR, DATA_W'(threshold_plan[p]));
      threshold_now = threshold_plan[p];
      if (p == 1) begin
        // write to a hole in the map must not move the threshold
        apb_access(1'b1, UNMAPPED_ADDR, '0);
      end
      apb_access(1'b0, THRESHOLD_ADDR, '0);
      send_random_rounds(ROUNDS_PER_PHASE);
    end

    settle();
    @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // result sink: changing stall patterns plus periodic long hold-offs
  initial begin : sink
    sink_mode_t  mode;
    int          mode_left;
    int          hold_left;
    int unsigned cycles;
    logic [15:0] pattern;
    result_ch.ready <= 1'b0;
    mode      = SINK_ALWAYS;
    mode_left = 0;
    hold_left = 0;
    cycles    = 0;
    pattern   = '1;
    forever begin
      @(posedge clk);
      cycles++;
      if (hold_left > 0) begin
        result_ch.ready <= 1'b0;
        hold_left--;
      end else if (cycles % HOLD_PERIOD == HOLD_PERIOD / 2) begin
        result_ch.ready <= 1'b0;
        hold_left = HOLD_LENGTH;
      end else begin
        if (mode_left == 0) begin
          mode      = sink_mode_t'($urandom_range(0, 2));
          mode_left = $urandom_range(10, 120);
          pattern   = 16'($urandom());
        end
        mode_left--;
        case (mode)
          SINK_PATTERN: begin
            result_ch.ready <= pattern[0];
            pattern = {pattern[0], pattern[15:1]};
          end
          SINK_RANDOM: begin
            result_ch.ready <= ($urandom_range(0, 2) != 0);
          end
          default: begin
            result_ch.ready <= 1'b1;
          end
        endcase
      end
    end
  end

  initial begin : watchdog
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
